// File: rtl/nkmt_pkg.sv
// ----------------------------------------------------------------------------
// nkmt_pkg
// Types and constants of the neighbor key match table.
// ----------------------------------------------------------------------------
package nkmt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int VALUE_BITS  = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    localparam int ARFCN_W = 10;
    localparam int KIND_W  = 2;
    localparam int CODE_W  = 9;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SIX   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NINE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNDEF = 2'd3;

    localparam logic [CODE_W-1:0] CODE6_MASK = 9'h03f;
    localparam logic [CODE_W-1:0] CODE9_MASK = 9'h1ff;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_RANGE     = 3'd2,
        ST_PRESENT   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        t_cmd                  cmd;
        logic [ARFCN_W-1:0]    arfcn;
        logic [KIND_W-1:0]     code_kind;
        logic [CODE_W-1:0]     bsic;
        logic [VALUE_BITS-1:0] cell_value;
    } t_in_item;

    typedef struct packed {
        t_status               status;
        logic [VALUE_BITS-1:0] found_value;
        logic [COUNT_W-1:0]    entry_count;
    } t_out_item;

endpackage

// File: rtl/neighbor_key_match_table.sv
// ----------------------------------------------------------------------------
// neighbor_key_match_table
// Ordered key/value table with exact and wildcard match on identity code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries commands:
//   add, lookup, delete, clear. Each item gives exactly one result on the
//   output channel (o_out_valid / i_out_stall / o_out_item) with a status,
//   the found value on a lookup hit, and the entry count afterwards.
//   Each accepted item passes an input register, then one pass of
//   parallel compare over all slots into the result register, which also
//   updates the table. The receiver can take the result at the next edge.
//   One item per cycle is sustained while the receiver does not stall; the
//   rate is set by that single compare/update pass.
//   When the receiver stalls, the result register holds, the input register
//   fills, and then o_in_stall rises until the result is taken.
//   Reset empties the table (entry count zero) and both registers; slot
//   contents are not cleared, since only slots below the count are read.
// ----------------------------------------------------------------------------
module neighbor_key_match_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  nkmt_pkg::t_in_item i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output nkmt_pkg::t_out_item o_out_item
);

    localparam int D = nkmt_pkg::TABLE_DEPTH;

    typedef logic [D-1:0] t_vec;

    // Table storage
    logic [nkmt_pkg::ARFCN_W-1:0]    r_slot_arfcn [D];
    logic [nkmt_pkg::KIND_W-1:0]     r_slot_kind  [D];
    logic [nkmt_pkg::CODE_W-1:0]     r_slot_code  [D];
    logic [nkmt_pkg::VALUE_BITS-1:0] r_slot_value [D];
    logic [nkmt_pkg::ARFCN_W-1:0]    n_slot_arfcn [D];
    logic [nkmt_pkg::KIND_W-1:0]     n_slot_kind  [D];
    logic [nkmt_pkg::CODE_W-1:0]     n_slot_code  [D];
    logic [nkmt_pkg::VALUE_BITS-1:0] n_slot_value [D];
    logic [nkmt_pkg::COUNT_W-1:0]    r_used;
    logic [nkmt_pkg::COUNT_W-1:0]    n_used;

    logic                r_in_vld;
    nkmt_pkg::t_in_item  r_in;
    logic                r_out_vld;
    nkmt_pkg::t_out_item r_out;
    nkmt_pkg::t_out_item n_out;

    logic out_free;
    logic work;

    t_vec slot_live, hit_exact, hit_wild, first_exact, last_wild, sel, at_or_above;
    logic [nkmt_pkg::CODE_W-1:0] mask;
    logic range_bad, add_ok, del_ok;
    logic [nkmt_pkg::VALUE_BITS-1:0] sel_value;

    function automatic t_vec lowest_one(t_vec v);
        return v & (~v + t_vec'(1));
    endfunction

    function automatic t_vec highest_one(t_vec v);
        t_vec rev, iso, res;
        for (int k = 0; k < D; k++) begin
            rev[k] = v[D-1-k];
        end
        iso = lowest_one(rev);
        for (int k = 0; k < D; k++) begin
            res[k] = iso[D-1-k];
        end
        return res;
    endfunction

    assign out_free   = !r_out_vld || !i_out_stall;
    assign work       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;

    // Parallel compare against every live slot
    always_comb begin
        for (int i = 0; i < D; i++) begin
            slot_live[i] = r_used > nkmt_pkg::COUNT_W'(i);
            mask = (r_slot_kind[i] == nkmt_pkg::KIND_SIX)  ? nkmt_pkg::CODE6_MASK :
                   (r_slot_kind[i] == nkmt_pkg::KIND_NINE) ? nkmt_pkg::CODE9_MASK :
                                                             '0;
            hit_exact[i] = slot_live[i]
                && r_slot_arfcn[i] == r_in.arfcn
                && r_slot_kind[i] != nkmt_pkg::KIND_UNDEF
                && r_slot_kind[i] == r_in.code_kind
                && (r_slot_code[i] & mask) == (r_in.bsic & mask);
            hit_wild[i] = hit_exact[i] || (slot_live[i]
                && r_slot_arfcn[i] == r_in.arfcn
                && r_slot_kind[i] != nkmt_pkg::KIND_UNDEF
                && (r_slot_kind[i] == nkmt_pkg::KIND_NONE
                    || r_in.code_kind == nkmt_pkg::KIND_NONE));
        end
    end

    assign first_exact = lowest_one(hit_exact);
    assign last_wild   = highest_one(hit_wild);
    assign sel         = (|hit_exact) ? first_exact : last_wild;
    // slots from the deleted one upward take their upper neighbor
    assign at_or_above = ~(first_exact - t_vec'(1));

    always_comb begin
        sel_value = '0;
        for (int i = 0; i < D; i++) begin
            sel_value = sel_value | ({nkmt_pkg::VALUE_BITS{sel[i]}} & r_slot_value[i]);
        end
    end

    assign range_bad = r_in.code_kind == nkmt_pkg::KIND_UNDEF
        || (r_in.code_kind == nkmt_pkg::KIND_SIX && r_in.bsic > nkmt_pkg::CODE6_MASK);

    always_comb begin
        n_out.status      = nkmt_pkg::ST_OK;
        n_out.found_value = '0;
        n_used            = r_used;
        add_ok            = 1'b0;
        del_ok            = 1'b0;
        unique case (r_in.cmd)
            nkmt_pkg::CMD_ADD: begin
                if (range_bad) begin
                    n_out.status = nkmt_pkg::ST_RANGE;
                end else if (|hit_exact) begin
                    n_out.status = nkmt_pkg::ST_PRESENT;
                end else if (r_used >= nkmt_pkg::COUNT_W'(D)) begin
                    n_out.status = nkmt_pkg::ST_FULL;
                end else begin
                    add_ok = 1'b1;
                    n_used = r_used + nkmt_pkg::COUNT_W'(1);
                end
            end
            nkmt_pkg::CMD_LOOKUP: begin
                if (|hit_wild) begin
                    n_out.found_value = sel_value;
                end else begin
                    n_out.status = nkmt_pkg::ST_NOT_FOUND;
                end
            end
            nkmt_pkg::CMD_DELETE: begin
                if (|hit_exact) begin
                    del_ok = 1'b1;
                    n_used = r_used - nkmt_pkg::COUNT_W'(1);
                end else begin
                    n_out.status = nkmt_pkg::ST_NOT_FOUND;
                end
            end
            nkmt_pkg::CMD_CLEAR: begin
                n_used = '0;
            end
            default: begin
                n_used = r_used;
            end
        endcase
        n_out.entry_count = n_used;
    end

    always_comb begin
        for (int i = 0; i < D; i++) begin
            n_slot_arfcn[i] = r_slot_arfcn[i];
            n_slot_kind[i]  = r_slot_kind[i];
            n_slot_code[i]  = r_slot_code[i];
            n_slot_value[i] = r_slot_value[i];
            if (add_ok && r_used[nkmt_pkg::IDX_W-1:0] == nkmt_pkg::IDX_W'(i)) begin
                n_slot_arfcn[i] = r_in.arfcn;
                n_slot_kind[i]  = r_in.code_kind;
                n_slot_code[i]  = r_in.bsic;
                n_slot_value[i] = r_in.cell_value;
            end
            if (i < D - 1) begin
                if (del_ok && at_or_above[i]) begin
                    n_slot_arfcn[i] = r_slot_arfcn[(i+1)%D];
                    n_slot_kind[i]  = r_slot_kind[(i+1)%D];
                    n_slot_code[i]  = r_slot_code[(i+1)%D];
                    n_slot_value[i] = r_slot_value[(i+1)%D];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_used    <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (out_free) begin
                r_out_vld <= r_in_vld;
            end
            if (work) begin
                r_used <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (work) begin
            r_out <= n_out;
            for (int i = 0; i < D; i++) begin
                r_slot_arfcn[i] <= n_slot_arfcn[i];
                r_slot_kind[i]  <= n_slot_kind[i];
                r_slot_code[i]  <= n_slot_code[i];
                r_slot_value[i] <= n_slot_value[i];
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= nkmt_pkg::COUNT_W'(D))
        else $error("entry count above table depth");

    a_grow_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        work && n_used > r_used |=> r_used == $past(r_used) + nkmt_pkg::COUNT_W'(1))
        else $error("table grew by more than one entry");

    a_value_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.found_value != '0 |-> o_out_item.status == nkmt_pkg::ST_OK)
        else $error("value reported with failing status");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == nkmt_pkg::ST_FULL
            |-> o_out_item.entry_count == nkmt_pkg::COUNT_W'(D))
        else $error("table full reported below depth");
`endif

endmodule

// File: dv/nkmt_table_checker.sv
// ----------------------------------------------------------------------------
// nkmt_table_checker
// Watches both channels of the neighbor key match table. It keeps its own
// copy of the ordered table, works out the result of every accepted command
// and compares each result taken from the block against the oldest one.
// ----------------------------------------------------------------------------
module nkmt_table_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  nkmt_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  nkmt_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);

    logic [nkmt_pkg::ARFCN_W-1:0]    tbl_arfcn [nkmt_pkg::TABLE_DEPTH];
    logic [nkmt_pkg::KIND_W-1:0]     tbl_kind  [nkmt_pkg::TABLE_DEPTH];
    logic [nkmt_pkg::CODE_W-1:0]     tbl_code  [nkmt_pkg::TABLE_DEPTH];
    logic [nkmt_pkg::VALUE_BITS-1:0] tbl_value [nkmt_pkg::TABLE_DEPTH];
    int                              tbl_used = 0;

    nkmt_pkg::t_out_item predicted_results [$];
    int                  mismatches   = 0;
    int                  results_seen = 0;

    assign o_fail_count = mismatches;
    assign o_checked    = results_seen;

    function automatic logic [nkmt_pkg::CODE_W-1:0] code_mask(
            input logic [nkmt_pkg::KIND_W-1:0] kind);
        case (kind)
            nkmt_pkg::KIND_SIX:  return nkmt_pkg::CODE6_MASK;
            nkmt_pkg::KIND_NINE: return nkmt_pkg::CODE9_MASK;
            default:             return '0;
        endcase
    endfunction

    // same channel, same kind, same code under the kind's mask
    function automatic bit key_exact(input int idx, input nkmt_pkg::t_in_item it);
        return tbl_arfcn[idx] == it.arfcn && tbl_kind[idx] == it.code_kind
            && ((tbl_code[idx] ^ it.bsic) & code_mask(it.code_kind)) == '0;
    endfunction

    function automatic int first_exact(input nkmt_pkg::t_in_item it);
        for (int i = 0; i < tbl_used; i++)
            if (key_exact(i, it))
                return i;
        return -1;
    endfunction

    function automatic nkmt_pkg::t_out_item apply_table_cmd(input nkmt_pkg::t_in_item it);
        nkmt_pkg::t_out_item res;
        int                  hit;
        res.status      = nkmt_pkg::ST_OK;
        res.found_value = '0;
        case (it.cmd)
            nkmt_pkg::CMD_ADD: begin
                if (it.code_kind > nkmt_pkg::KIND_NINE
                        || (it.code_kind == nkmt_pkg::KIND_SIX
                            && it.bsic > nkmt_pkg::CODE6_MASK))
                    res.status = nkmt_pkg::ST_RANGE;
                else if (first_exact(it) >= 0)
                    res.status = nkmt_pkg::ST_PRESENT;
                else if (tbl_used >= nkmt_pkg::TABLE_DEPTH)
                    res.status = nkmt_pkg::ST_FULL;
                else begin
                    tbl_arfcn[tbl_used] = it.arfcn;
                    tbl_kind[tbl_used]  = it.code_kind;
                    tbl_code[tbl_used]  = it.bsic;
                    tbl_value[tbl_used] = it.cell_value;
                    tbl_used++;
                end
            end
            nkmt_pkg::CMD_LOOKUP: begin
                // first exact hit wins, else the last wildcard hit
                hit = -1;
                for (int i = 0; i < tbl_used; i++) begin
                    if (key_exact(i, it)) begin
                        hit = i;
                        break;
                    end
                    if (tbl_arfcn[i] == it.arfcn
                            && (tbl_kind[i] == nkmt_pkg::KIND_NONE
                                || it.code_kind == nkmt_pkg::KIND_NONE))
                        hit = i;
                end
                if (hit < 0)
                    res.status = nkmt_pkg::ST_NOT_FOUND;
                else
                    res.found_value = tbl_value[hit];
            end
            nkmt_pkg::CMD_DELETE: begin
                hit = first_exact(it);
                if (hit < 0)
                    res.status = nkmt_pkg::ST_NOT_FOUND;
                else begin
                    // close the gap, keeping insertion order
                    for (int i = hit; i < tbl_used - 1; i++) begin
                        tbl_arfcn[i] = tbl_arfcn[i + 1];
                        tbl_kind[i]  = tbl_kind[i + 1];
                        tbl_code[i]  = tbl_code[i + 1];
                        tbl_value[i] = tbl_value[i + 1];
                    end
                    tbl_used--;
                end
            end
            default: tbl_used = 0;
        endcase
        res.entry_count = nkmt_pkg::COUNT_W'(tbl_used);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check
        nkmt_pkg::t_out_item want;
        if (!i_rst_n) begin
            predicted_results.delete();
            tbl_used = 0;
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (predicted_results.size() == 0)
                    report_mismatch("result with no command pending",
                                    32'(i_out_item), 32'd0);
                else begin
                    want = predicted_results.pop_front();
                    if (i_out_item.status !== want.status)
                        report_mismatch("status", 32'(i_out_item.status),
                                        32'(want.status));
                    if (i_out_item.found_value !== want.found_value)
                        report_mismatch("found_value", 32'(i_out_item.found_value),
                                        32'(want.found_value));
                    if (i_out_item.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(i_out_item.entry_count),
                                        32'(want.entry_count));
                end
            end
            if (i_in_valid && !i_in_stall)
                predicted_results.push_back(apply_table_cmd(i_in_item));
            o_pending <= predicted_results.size();
        end
    end

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives commands into the neighbor key match table: a directed set of key
// corner cases, a full-table phase under a long output hold-off, deletes
// that force compaction, then a random mix on a small key pool with noise.
// Sender bursts and receiver stalls are random; the checker does the compare.
// ----------------------------------------------------------------------------
module tb;

    localparam int HOLD_CYCLES  = 60;
    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_ITEMS = 360;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    nkmt_pkg::t_in_item  in_item   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    nkmt_pkg::t_out_item out_item;

    logic hold_req   = 1'b0;
    bit   gaps_on    = 1'b1;
    int   burst_left = 0;
    int   cmd_count [4];
    int   fail_count;
    int   pending;
    int   checked;

    neighbor_key_match_table u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    nkmt_table_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("no item moved for %0d cycles", IDLE_LIMIT);
        $display("neighbor_key_match_table test failed");
        $finish;
    end

    // receiver: stall-free, light and heavy stretches, plus one long hold-off
    initial begin : rx_pattern
        int rx_cycle;
        int hold_left;
        rx_cycle  = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if ((rx_cycle / 150) % 3 == 0)
                out_stall <= 1'b0;
            else if ((rx_cycle / 150) % 3 == 1)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 99) < 60);
        end
    end

    function automatic nkmt_pkg::t_in_item make_item(
            input nkmt_pkg::t_cmd                  op,
            input logic [nkmt_pkg::ARFCN_W-1:0]    chan,
            input logic [nkmt_pkg::KIND_W-1:0]     kind,
            input logic [nkmt_pkg::CODE_W-1:0]     code,
            input logic [nkmt_pkg::VALUE_BITS-1:0] val);
        nkmt_pkg::t_in_item it;
        it.cmd        = op;
        it.arfcn      = chan;
        it.code_kind  = kind;
        it.bsic       = code;
        it.cell_value = val;
        return it;
    endfunction

    // offer one item, hold it until taken, then maybe leave a gap
    task automatic send_cmd(input nkmt_pkg::t_in_item item);
        in_item  <= item;
        in_valid <= 1'b1;
        cmd_count[item.cmd]++;
        do @(posedge clk); while (in_stall);
        if (gaps_on) begin
            if (burst_left > 0)
                burst_left--;
            else begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(0, 6);
            end
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    initial begin : stimulus
        logic [nkmt_pkg::ARFCN_W-1:0] fill_arfcn [17];
        logic [nkmt_pkg::CODE_W-1:0]  fill_code  [17];
        logic [nkmt_pkg::CODE_W-1:0]  code6_over;
        int                           order [16];
        int                           j;
        int                           tmp;
        int                           roll;
        nkmt_pkg::t_in_item           it;

        code6_over = nkmt_pkg::CODE_W'(nkmt_pkg::CODE6_MASK + 1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, range checks, duplicates, wildcard rules
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '0, nkmt_pkg::KIND_NONE, '0, '0));
        send_cmd(make_item(nkmt_pkg::CMD_DELETE, '1, nkmt_pkg::KIND_NINE,
                           nkmt_pkg::CODE9_MASK, '0));
        send_cmd(make_item(nkmt_pkg::CMD_ADD, '0, nkmt_pkg::KIND_NONE, '0, '0));
        send_cmd(make_item(nkmt_pkg::CMD_ADD, '1, nkmt_pkg::KIND_SIX,
                           nkmt_pkg::CODE6_MASK, '1));
        send_cmd(make_item(nkmt_pkg::CMD_ADD, '1, nkmt_pkg::KIND_SIX, code6_over,
                           16'h0bad));
        send_cmd(make_item(nkmt_pkg::CMD_ADD, 10'd5, nkmt_pkg::KIND_UNDEF, '0,
                           16'h0bad));
        send_cmd(make_item(nkmt_pkg::CMD_ADD, '1, nkmt_pkg::KIND_NINE,
                           nkmt_pkg::CODE9_MASK, 16'h5a5a));
        send_cmd(make_item(nkmt_pkg::CMD_ADD, '1, nkmt_pkg::KIND_SIX,
                           nkmt_pkg::CODE6_MASK, 16'h1234));
        // code is ignored for kind none, so this one is a duplicate
        send_cmd(make_item(nkmt_pkg::CMD_ADD, '0, nkmt_pkg::KIND_NONE,
                           nkmt_pkg::CODE9_MASK, 16'h0001));
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '1, nkmt_pkg::KIND_SIX,
                           nkmt_pkg::CODE6_MASK, '0));
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '1, nkmt_pkg::KIND_NONE, '0, '0));
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '0, nkmt_pkg::KIND_NINE, 9'd300, '0));
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '0, nkmt_pkg::KIND_UNDEF, 9'd7, '0));
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '1, nkmt_pkg::KIND_UNDEF,
                           nkmt_pkg::CODE6_MASK, '0));
        send_cmd(make_item(nkmt_pkg::CMD_DELETE, '1, nkmt_pkg::KIND_UNDEF,
                           nkmt_pkg::CODE6_MASK, '0));
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '1, nkmt_pkg::KIND_SIX, 9'd62, '0));
        send_cmd(make_item(nkmt_pkg::CMD_ADD, '1, nkmt_pkg::KIND_NINE,
                           nkmt_pkg::CODE6_MASK, 16'ha5a5));
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '1, nkmt_pkg::KIND_NINE,
                           nkmt_pkg::CODE6_MASK, '0));
        send_cmd(make_item(nkmt_pkg::CMD_DELETE, '1, nkmt_pkg::KIND_SIX,
                           nkmt_pkg::CODE6_MASK, '0));
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '1, nkmt_pkg::KIND_SIX, 9'd5, '0));
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '1, nkmt_pkg::KIND_NINE,
                           nkmt_pkg::CODE9_MASK, '0));
        send_cmd(make_item(nkmt_pkg::CMD_ADD, '1, nkmt_pkg::KIND_NONE, '0, 16'h7777));
        send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, '1, nkmt_pkg::KIND_SIX, 9'd5, '0));
        send_cmd(make_item(nkmt_pkg::CMD_CLEAR, '0, nkmt_pkg::KIND_NONE, '0, '0));
        drain_results();

        // fill to the last slot, one add too many, one duplicate on a full table
        for (int i = 0; i < 17; i++) begin
            fill_arfcn[i] = nkmt_pkg::ARFCN_W'(i * 60 + $urandom_range(0, 59));
            fill_code[i]  = nkmt_pkg::CODE_W'($urandom);
            send_cmd(make_item(nkmt_pkg::CMD_ADD, fill_arfcn[i], nkmt_pkg::KIND_NINE,
                               fill_code[i], nkmt_pkg::VALUE_BITS'($urandom)));
        end
        send_cmd(make_item(nkmt_pkg::CMD_ADD, fill_arfcn[3], nkmt_pkg::KIND_NINE,
                           fill_code[3], '1));

        // back-to-back lookups while the receiver holds off
        gaps_on = 1'b0;
        hold_req <= 1'b1;
        for (int n = 0; n < 40; n++) begin
            j = $urandom_range(0, 16);
            send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, fill_arfcn[j],
                               ($urandom_range(0, 3) == 0) ? nkmt_pkg::KIND_NONE
                                                           : nkmt_pkg::KIND_NINE,
                               fill_code[j], '0));
        end
        gaps_on = 1'b1;
        drain_results();

        // delete half in random order, then look every key up again
        for (int i = 0; i < 16; i++)
            order[i] = i;
        for (int i = 15; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 8; i++)
            send_cmd(make_item(nkmt_pkg::CMD_DELETE, fill_arfcn[order[i]],
                               nkmt_pkg::KIND_NINE, fill_code[order[i]], '0));
        for (int i = 0; i < 17; i++)
            send_cmd(make_item(nkmt_pkg::CMD_LOOKUP, fill_arfcn[i], nkmt_pkg::KIND_NINE,
                               fill_code[i], '0));

        // random mix: mostly a small key pool so keys collide, some raw noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            roll = $urandom_range(0, 99);
            it.cmd = roll < 40 ? nkmt_pkg::CMD_ADD : roll < 75 ? nkmt_pkg::CMD_LOOKUP
                   : roll < 98 ? nkmt_pkg::CMD_DELETE : nkmt_pkg::CMD_CLEAR;
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 5))
                    0:       it.arfcn = '0;
                    1:       it.arfcn = '1;
                    2:       it.arfcn = 10'd17;
                    3:       it.arfcn = 10'd18;
                    4:       it.arfcn = 10'd600;
                    default: it.arfcn = nkmt_pkg::ARFCN_W'($urandom);
                endcase
                roll = $urandom_range(0, 19);
                it.code_kind = roll < 4 ? nkmt_pkg::KIND_NONE
                             : roll < 11 ? nkmt_pkg::KIND_SIX
                             : roll < 18 ? nkmt_pkg::KIND_NINE : nkmt_pkg::KIND_UNDEF;
                case ($urandom_range(0, 9))
                    6:       it.bsic = nkmt_pkg::CODE6_MASK;
                    7:       it.bsic = code6_over;
                    8:       it.bsic = nkmt_pkg::CODE9_MASK;
                    9:       it.bsic = nkmt_pkg::CODE_W'($urandom);
                    default: it.bsic = nkmt_pkg::CODE_W'($urandom_range(0, 3));
                endcase
            end else begin
                it.arfcn     = nkmt_pkg::ARFCN_W'($urandom);
                it.code_kind = nkmt_pkg::KIND_W'($urandom);
                it.bsic      = nkmt_pkg::CODE_W'($urandom);
            end
            it.cell_value = nkmt_pkg::VALUE_BITS'($urandom);
            send_cmd(it);
        end

        drain_results();
        repeat (4) @(posedge clk);

        $display("ran %0d add, %0d lookup, %0d delete, %0d clear items; %0d results checked",
                 cmd_count[nkmt_pkg::CMD_ADD], cmd_count[nkmt_pkg::CMD_LOOKUP],
                 cmd_count[nkmt_pkg::CMD_DELETE], cmd_count[nkmt_pkg::CMD_CLEAR], checked);
        $display("included a full table, a long output hold-off and delete compaction");
        if (fail_count == 0 && pending == 0)
            $display("neighbor_key_match_table test passed");
        else
            $display("neighbor_key_match_table test failed");
        $finish;
    end

endmodule
